@@ hdl/ksfr_pkg.sv @@
// ----------------------------------------------------------------------------
// ksfr_pkg
// Shared types and constants for the kappa-sigma frame rejection core.
// ----------------------------------------------------------------------------
`default_nettype none

package ksfr_pkg;

  localparam int MAX_FRAMES_DEF = 32;
  localparam int MIN_FRAMES     = 3;
  localparam int MEAN_W         = 24;
  localparam int KAPPA_W        = 12;
  localparam int MINV_W         = 6;
  localparam int IDX_W          = 5;
  localparam int CNT_OUT_W      = 6;
  localparam int CFG_W          = 12;

  localparam logic [KAPPA_W-1:0] KAPPA_RST = 12'd512;
  localparam logic [MINV_W-1:0]  MINV_RST  = 6'd3;

  // register indexes
  localparam logic CFG_KAPPA     = 1'b0;
  localparam logic CFG_MIN_VALID = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_LOWVALID = 2'd2;

  typedef struct packed {
    logic [MEAN_W-1:0] frame_mean;
    logic              last;
  } ksfr_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]     frame_index;
    logic                 keep;
    logic [CNT_OUT_W-1:0] valid_count;
    logic [1:0]           status;
    logic                 final_res;
  } ksfr_out_t;

endpackage

`default_nettype wire

@@ hdl/ksfr_ram.sv @@
// ----------------------------------------------------------------------------
// ksfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksfr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/ksfr_div.sv @@
// ----------------------------------------------------------------------------
// ksfr_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module ksfr_div #(
  parameter int DW = 54,
  parameter int RW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dq;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   dsr;
  logic [RW:0]     trial;
  logic            qbit;

  assign trial    = {rem, dq[DW-1]};
  assign qbit     = trial >= {1'b0, dsr};
  assign quotient = dq;

  // shift dividend out and quotient bits in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? RW'(trial - {1'b0, dsr}) : trial[RW-1:0];
        dq  <= {dq[DW-2:0], qbit};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/ksfr_isqrt.sv @@
// ----------------------------------------------------------------------------
// ksfr_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ksfr_isqrt #(
  parameter int IW = 54
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [IW-1:0]   radicand,
  output logic                 done,
  output logic      [IW/2-1:0] root
);

  localparam int HW   = IW / 2;
  localparam int RMW  = HW + 2;
  localparam int CNTW = $clog2(HW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [IW-1:0]   rad;
  logic [RMW-1:0]  rem;
  logic [RMW-1:0]  rem_sh;
  logic [RMW-1:0]  trial;
  logic            fit;

  assign rem_sh = {rem[RMW-3:0], rad[IW-1:IW-2]};
  assign trial  = {root, 2'b01};
  assign fit    = rem_sh >= trial;

  // settle one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= fit ? rem_sh - trial : rem_sh;
        root <= {root[HW-2:0], fit};
        rad  <= {rad[IW-3:0], 2'b00};
        cnt  <= cnt + CNTW'(1);
        if (cnt == CNTW'(HW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/kappa_sigma_frame_rejection_core.sv @@
// ----------------------------------------------------------------------------
// kappa_sigma_frame_rejection_core
// Loads frame means, then rejects frames outside average +/- kappa*sigma.
// ----------------------------------------------------------------------------
// Frame means are taken one per cycle, while the input is not stalled, into an
// internal RAM until a request with the last mark arrives; the input then stalls
// until every result of the run has been delivered. With n frames loaded, a run
// divides the sum by n for the average, makes the variance pass over the RAM
// (RAM read, difference, square, accumulate), divides the squared sum by n-1 on
// the same serial divider, takes the square root, forms kappa*sigma, makes the
// keep pass over the RAM, sets the status and emits one result per frame. The
// divider works on V = 48 + clog2(MAX_FRAMES+1) bits (54 at the default size).
// A run of fewer than three frames returns one result with the too-few status
// at once.
`default_nettype none

module kappa_sigma_frame_rejection_core #(
  parameter int MAX_FRAMES = ksfr_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr,
  input  wire logic                     cfg_addr,
  input  wire logic [ksfr_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire ksfr_pkg::ksfr_in_t       in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output ksfr_pkg::ksfr_out_t           out_data
);

  import ksfr_pkg::*;

  localparam int AW   = $clog2(MAX_FRAMES);
  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int SW   = MEAN_W + CW;
  localparam int VW   = 2 * MEAN_W + CW;
  localparam int SQW  = VW + (VW % 2);
  localparam int RTW  = SQW / 2;
  localparam int KSW  = KAPPA_W + RTW;
  localparam int CMW  = KSW + 2;
  localparam int NVW  = (CW > MINV_W) ? CW : MINV_W;

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_AVG  = 9'b000000010,
    S_VAR  = 9'b000000100,
    S_VDIV = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_KS   = 9'b000100000,
    S_KEEP = 9'b001000000,
    S_STAT = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t               state;
  logic [KAPPA_W-1:0]   kappa;
  logic [MINV_W-1:0]    min_valid;
  logic [CW-1:0]        count;
  logic [SW-1:0]        sum;
  logic [MEAN_W-1:0]    avg;
  logic [VW-1:0]        vacc;
  logic [MEAN_W-1:0]    diff;
  logic [2*MEAN_W-1:0]  prod;
  logic [RTW-1:0]       sig;
  logic [KSW-1:0]       ks;
  logic [MAX_FRAMES-1:0] keepv;
  logic [CW-1:0]        nval;
  logic [CW-1:0]        idx;
  logic [1:0]           ph;
  logic [1:0]           status;

  logic                 in_acc;
  logic                 full;
  logic [CW-1:0]        count_next;
  logic [SW-1:0]        sum_next;
  logic                 out_free;
  logic                 idx_last;

  logic                 ram_we;
  logic [MEAN_W-1:0]    rdata;

  logic                 div_start;
  logic [VW-1:0]        div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic [VW-1:0]        div_quot;

  logic                 sq_start;
  logic                 sq_done;
  logic [RTW-1:0]       sq_root;

  logic [CMW-1:0]       v_ext;
  logic [CMW-1:0]       center;
  logic [CMW-1:0]       ks_ext;
  logic                 keep_now;

  assign in_stall   = (state != S_LOAD) || out_valid;
  assign in_acc     = in_valid && !in_stall;
  assign full       = count == CW'(MAX_FRAMES);
  assign count_next = full ? count : count + CW'(1);
  assign sum_next   = full ? sum : sum + SW'(in_data.frame_mean);
  assign ram_we     = in_acc && !full;
  assign out_free   = !out_valid || !out_stall;
  assign idx_last   = (idx + CW'(1)) == count;

  // compare in units of 2^-8 without rounding
  assign v_ext    = CMW'(rdata) << 8;
  assign center   = CMW'(avg) << 8;
  assign ks_ext   = CMW'(ks);
  assign keep_now = ((v_ext + ks_ext) > center) && (v_ext < (center + ks_ext));

  // start the shared divider for the average or the variance
  always_comb begin
    div_start    = 1'b0;
    div_dividend = VW'(sum_next);
    div_divisor  = count_next;
    if (state == S_LOAD && in_acc && in_data.last
        && count_next >= CW'(MIN_FRAMES)) begin
      div_start = 1'b1;
    end else if (state == S_VAR && ph == 2'd3 && idx_last) begin
      div_start    = 1'b1;
      div_dividend = vacc + VW'(prod);
      div_divisor  = count - CW'(1);
    end
  end

  assign sq_start = (state == S_VDIV) && div_done;

  ksfr_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (in_data.frame_mean),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  ksfr_div #(
    .DW (VW),
    .RW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  ksfr_isqrt #(
    .IW (SQW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (SQW'(div_quot)),
    .done     (sq_done),
    .root     (sq_root)
  );

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kappa     <= KAPPA_RST;
      min_valid <= MINV_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        CFG_KAPPA:     kappa     <= cfg_data[KAPPA_W-1:0];
        CFG_MIN_VALID: min_valid <= cfg_data[MINV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence load, statistics, keep pass and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sum       <= '0;
      idx       <= '0;
      ph        <= '0;
      nval      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in_data.last && count_next < CW'(MIN_FRAMES)) begin
              out_valid            <= 1'b1;
              out_data.frame_index <= '0;
              out_data.keep        <= 1'b0;
              out_data.valid_count <= '0;
              out_data.status      <= ST_FEW;
              out_data.final_res   <= 1'b1;
              count                <= '0;
              sum                  <= '0;
            end else begin
              count <= count_next;
              sum   <= sum_next;
              if (in_data.last) begin
                state <= S_AVG;
              end
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg   <= div_quot[MEAN_W-1:0];
            idx   <= '0;
            ph    <= '0;
            vacc  <= '0;
            state <= S_VAR;
          end
        end
        S_VAR: begin
          ph <= ph + 2'd1;
          case (ph)
            2'd1: diff <= (rdata >= avg) ? rdata - avg : avg - rdata;
            2'd2: prod <= diff * diff;
            2'd3: begin
              vacc <= vacc + VW'(prod);
              idx  <= idx + CW'(1);
              if (idx_last) begin
                state <= S_VDIV;
              end
            end
            default: ;
          endcase
        end
        S_VDIV: begin
          if (div_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sig   <= sq_root;
            state <= S_KS;
          end
        end
        S_KS: begin
          ks    <= KSW'(kappa) * KSW'(sig);
          idx   <= '0;
          ph    <= '0;
          nval  <= '0;
          state <= S_KEEP;
        end
        S_KEEP: begin
          ph[0] <= !ph[0];
          if (ph[0]) begin
            keepv[idx[AW-1:0]] <= keep_now;
            nval               <= nval + CW'(keep_now);
            idx                <= idx + CW'(1);
            if (idx_last) begin
              state <= S_STAT;
            end
          end
        end
        S_STAT: begin
          status <= (NVW'(nval) < NVW'(min_valid)) ? ST_LOWVALID : ST_OK;
          idx    <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.frame_index <= IDX_W'(idx);
            out_data.keep        <= keepv[idx[AW-1:0]];
            out_data.valid_count <= CNT_OUT_W'(nval);
            out_data.status      <= status;
            out_data.final_res   <= idx_last;
            idx                  <= idx + CW'(1);
            if (idx_last) begin
              count <= '0;
              sum   <= '0;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ksfr_checker.sv @@
// ----------------------------------------------------------------------------
// ksfr_checker
// Port-level checks on the result channel of the frame rejection core.
// ----------------------------------------------------------------------------
`default_nettype none

module ksfr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire ksfr_pkg::ksfr_out_t        out_data
);

  import ksfr_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no undefined status code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

  // a too-few run gives one empty final result
  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FEW |->
      out_data.final_res && !out_data.keep && out_data.valid_count == '0
      && out_data.frame_index == '0)
    else $error("malformed too-few result");

  // a kept frame implies a nonzero kept count
  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.keep |-> out_data.valid_count != '0)
    else $error("kept frame with zero count");

endmodule

bind kappa_sigma_frame_rejection_core ksfr_checker u_ksfr_checker (.*);

`default_nettype wire

@@ dv/kappa_sigma_frame_rejection_core_tb.sv @@
// ----------------------------------------------------------------------------
// kappa_sigma_frame_rejection_core_tb
// Self-checking bench: loads frame sets, predicts per-frame keep decisions
// from an internal statistics calculation and compares every result field.
// ----------------------------------------------------------------------------
`default_nettype none

module kappa_sigma_frame_rejection_core_tb;
  import ksfr_pkg::*;

  localparam int NFR   = MAX_FRAMES_DEF;
  localparam int LIMIT = 2000000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr = 1'b0;
  logic            cfg_addr = CFG_KAPPA;
  logic [CFG_W-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  ksfr_in_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  ksfr_out_t       out_data;

  // predictor state
  logic [MEAN_W-1:0]  set_means [NFR];
  int unsigned        set_len;
  logic [63:0]        set_sum;
  logic [KAPPA_W-1:0] kappa_q;
  logic [MINV_W-1:0]  min_kept;
  ksfr_out_t          verdict_q [$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned sets_sent = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_off = 0;

  kappa_sigma_frame_rejection_core i_dut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // load one mean into the predictor; on the last mark, queue the verdicts
  task automatic predict_frame(ksfr_in_t r);
    logic [63:0] avg, var_acc, d, sig, ks, ctr, v;
    int unsigned nk;
    bit          kf [NFR];
    ksfr_out_t   o;
    if (set_len < NFR) begin
      set_means[set_len] = r.frame_mean;
      set_sum = set_sum + r.frame_mean;
      set_len++;
    end
    if (!r.last) return;
    if (set_len < MIN_FRAMES) begin
      o = '0;
      o.status = ST_FEW;
      o.final_res = 1'b1;
      verdict_q.push_back(o);
    end else begin
      avg = set_sum / set_len;
      var_acc = 0;
      for (int i = 0; i < set_len; i++) begin
        v = 64'(set_means[i]);
        d = (v >= avg) ? v - avg : avg - v;
        var_acc = var_acc + d * d;
      end
      var_acc = var_acc / (set_len - 1);
      sig = int_root(var_acc);
      ks = kappa_q * sig;
      ctr = avg << 8;
      nk = 0;
      for (int i = 0; i < set_len; i++) begin
        v = 64'(set_means[i]) << 8;
        kf[i] = (v + ks > ctr) && (v < ctr + ks);
        if (kf[i]) nk++;
      end
      for (int i = 0; i < set_len; i++) begin
        o.frame_index = i[IDX_W-1:0];
        o.keep = kf[i];
        o.valid_count = nk[CNT_OUT_W-1:0];
        o.status = (nk < min_kept) ? ST_LOWVALID : ST_OK;
        o.final_res = (i + 1 == set_len);
        verdict_q.push_back(o);
      end
    end
    set_len = 0;
    set_sum = 0;
    sets_sent++;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
             want);
  endtask

  // drop the request line and wait for a clock edge
  task automatic idle_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one request, with an optional random gap before it
  task automatic send_frame(logic [MEAN_W-1:0] m, bit lst);
    ksfr_in_t r;
    int unsigned gap;
    r.frame_mean = m;
    r.last = lst;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(r);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    // wait for drain; each set ends in results, so only a short settle is needed
    idle_in();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr <= 1'b0;
    if (idx == CFG_KAPPA) kappa_q = val[KAPPA_W-1:0];
    else min_kept = val[MINV_W-1:0];
  endtask

  task automatic send_set(int unsigned n, logic [MEAN_W-1:0] base, int unsigned spread);
    logic [MEAN_W-1:0] m;
    for (int i = 0; i < n; i++) begin
      m = base + $urandom_range(0, spread);
      send_frame(m, i == n - 1);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ksfr_out_t w;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report("unexpected frame_index", out_data.frame_index, 0);
      end else begin
        w = verdict_q.pop_front();
        if (out_data.frame_index !== w.frame_index)
          report("frame_index", out_data.frame_index, w.frame_index);
        if (out_data.keep !== w.keep) report("keep", out_data.keep, w.keep);
        if (out_data.valid_count !== w.valid_count)
          report("valid_count", out_data.valid_count, w.valid_count);
        if (out_data.status !== w.status) report("status", out_data.status, w.status);
        if (out_data.final_res !== w.final_res)
          report("final_res", out_data.final_res, w.final_res);
      end
      results_seen <= results_seen + 1;
    end
  end

  // receiver stall bursts, plus the long hold-off
  initial begin
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    // too few frames: one and two loaded
    send_frame(24'h000000, 1'b1);
    send_frame(24'hFFFFFF, 1'b0);
    send_frame(24'hFFFFFF, 1'b1);
    // zero sigma: all equal
    send_frame(24'h123456, 1'b0);
    send_frame(24'h123456, 1'b0);
    send_frame(24'h123456, 1'b1);
    // extremes and mid-range values
    send_frame(24'h000000, 1'b0);
    send_frame(24'hFFFFFF, 1'b0);
    send_frame(24'h800000, 1'b0);
    send_frame(24'h7FFFFF, 1'b0);
    send_frame(24'h800001, 1'b1);
    // alternating bit patterns
    send_frame(24'hAAAAAA, 1'b0);
    send_frame(24'h555555, 1'b0);
    send_frame(24'hAAAAAB, 1'b1);
  endtask

  task automatic test_store_full();
    // overflow the store; dropped frames must not count, last still closes
    send_set(35, 24'h400000, 4000);
    send_set(NFR, 24'hFFFF00, 255);
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_KAPPA, 12'd0);
    send_set(6, 24'h001000, 300);
    write_reg(CFG_KAPPA, 12'hFFF);
    write_reg(CFG_MIN_VALID, 12'd32);
    send_set(NFR, 24'h200000, 50000);
    write_reg(CFG_MIN_VALID, 12'd0);
    write_reg(CFG_KAPPA, 12'd256);
    send_set(10, 24'h000000, 24'hFFFFFF);
    write_reg(CFG_KAPPA, 12'd64);
    write_reg(CFG_MIN_VALID, 12'd5);
    send_set(12, 24'h100000, 1000);
  endtask

  task automatic test_backpressure();
    // hold the receiver while the sender keeps offering frames
    hold_off = 1000;
    send_set(20, 24'h300000, 2000);
    send_set(8, 24'h300000, 2000);
    idle_in();
    while (hold_off != 0) @(posedge clk);
  endtask

  task automatic test_random(int unsigned target);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < target) begin
      if (sent > (target * 3) / 4) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_KAPPA : CFG_MIN_VALID,
                  $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                                       : 12'($urandom_range(0, 8)));
        if (min_kept > 32) write_reg(CFG_MIN_VALID, 12'd32);
      end
      case ($urandom_range(0, 7))
        0: n = $urandom_range(1, 2);
        1: n = $urandom_range(30, 34);
        default: n = $urandom_range(3, 12);
      endcase
      if ($urandom_range(0, 3) == 0)
        send_set(n, 24'($urandom), 32'($urandom_range(0, 24'hFFFFFF)));
      else
        send_set(n, 24'($urandom_range(0, 24'hFF0000)), $urandom_range(0, 65535));
      sent += n;
    end
  endtask

  initial begin
    set_len = 0;
    set_sum = 0;
    kappa_q = KAPPA_RST;
    min_kept = MINV_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_config_sweep();
    test_backpressure();
    test_random(320);
    idle_in();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d frame sets, %0d results, including short sets, full stores,",
             sets_sent, results_seen);
    $display("kappa and min_valid extremes and a long output hold-off");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ kappa_sigma_frame_rejection_core.f @@
hdl/ksfr_pkg.sv
hdl/ksfr_ram.sv
hdl/ksfr_div.sv
hdl/ksfr_isqrt.sv
hdl/kappa_sigma_frame_rejection_core.sv
hdl/ksfr_checker.sv
dv/kappa_sigma_frame_rejection_core_tb.sv
